// File: src/rprop_step_size_optimizer_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the rprop step-size optimizer core
// Concurrent checks are compiled only outside synthesis.
// ---------------------------------------------------------------------------
`ifndef RPROP_STEP_SIZE_OPTIMIZER_CORE_DEFINES_SVH
`define RPROP_STEP_SIZE_OPTIMIZER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Check that is suspended while reset is asserted.
`define RSO_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("rso assertion failed");

// Check that also holds across reset.
`define RSO_ASSERT_RST(name, prop) \
  name: assert property (@(posedge clk) (prop)) \
    else $error("rso reset assertion failed");

`else

`define RSO_ASSERT(name, prop)
`define RSO_ASSERT_RST(name, prop)

`endif

`endif

// File: src/rso_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rso_pkg
// Types and constants of the rprop step-size optimizer core.
// ---------------------------------------------------------------------------
package rso_pkg;

  localparam int SLOTS  = 16;
  localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Reset values of the configuration registers.
  localparam logic [31:0] STEP_INIT_RST = 32'd1677722;
  localparam logic [31:0] STEP_MIN_RST  = 32'd17;
  localparam logic [31:0] STEP_MAX_RST  = 32'd838860800;
  localparam logic [12:0] SHRINK_RST    = 13'd2048;
  localparam logic [15:0] GROW_RST      = 16'd4915;
  localparam logic [63:0] STOP_THR_RST  = 64'd0;

  localparam logic signed [31:0] PARAM_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] PARAM_MIN = 32'sh8000_0000;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_GRAD = 2'd1,
    OP_LIKE = 2'd2,
    OP_READ = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    CFG_STEP_INIT = 3'd0,
    CFG_STEP_MIN  = 3'd1,
    CFG_STEP_MAX  = 3'd2,
    CFG_SHRINK    = 3'd3,
    CFG_GROW      = 3'd4,
    CFG_STOP_THR  = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    SIGN_ZERO = 2'b00,
    SIGN_POS  = 2'b01,
    SIGN_NEG  = 2'b11
  } sign_t;

  // One entry of the slot memory.
  typedef struct packed {
    sign_t              sign;
    logic [31:0]        step;
    logic signed [31:0] param;
  } slot_word_t;

  // Result of the update stage on its way to the norm and output stage.
  typedef struct packed {
    logic signed [31:0] param;
    logic [31:0]        step;
    logic               improved;
    logic               round_end;
    logic [63:0]        grad_sq;
  } upd_res_t;

endpackage

// File: src/rprop_step_size_optimizer_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rprop_step_size_optimizer_core
// iRprop- update engine with best-parameter snapshot and stop detection.
// ---------------------------------------------------------------------------
// The block takes one item per clock while the output side does not stall and
// returns its result through the update, result and output registers. Parameter,
// step and previous sign of each slot share one synchronous memory, the best
// parameters sit in a second one; each is read when an item is accepted and
// written back from the update stage, so an item on the same slot right behind gets
// the written word through a bypass register. A likelihood improvement does
// not copy the memory: a flag per slot marks that the best value still equals
// the current parameter, and the old value is saved to the best memory the
// first time a gradient moves that slot afterward. The squared-norm sum is
// kept in the output stage. Only a stalled output holds back input transfers;
// no clearing pass follows reset.
// ---------------------------------------------------------------------------
`include "rprop_step_size_optimizer_core_defines.svh"

module rprop_step_size_optimizer_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_operation,
  input  logic [3:0]         in_index,
  input  logic signed [31:0] in_value,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_param_value,
  output logic [31:0]        out_step_size,
  output logic               out_stop,
  output logic               out_improved,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data
);

  localparam int SLOTS  = rso_pkg::SLOTS;
  localparam int ADDR_W = rso_pkg::ADDR_W;

  // Configuration registers.
  logic [31:0] step_init_r, step_min_r, step_max_r;
  logic [12:0] shrink_r;
  logic [15:0] grow_r;
  logic [63:0] stop_thr_r;

  // Memories.
  rso_pkg::slot_word_t       slot_mem [SLOTS];
  logic signed [31:0]        best_mem [SLOTS];

  // Update stage.
  logic                      s1_v_r;
  rso_pkg::op_t              s1_op_r;
  logic [3:0]                s1_idx_r;
  logic signed [31:0]        s1_val_r;
  logic                      s1_last_r;
  rso_pkg::slot_word_t       slot_rd_r, fwd_a_r;
  logic signed [31:0]        best_rd_r, fwd_b_r;
  logic                      fwd_a_hit_r, fwd_b_hit_r;

  // Per-slot flags and likelihood tracking.
  logic [SLOTS-1:0]          init_r;
  logic [SLOTS-1:0]          snap_r;
  logic [SLOTS-1:0]          snap_nxt;
  logic signed [31:0]        best_score_r;
  logic                      best_valid_r;

  // Result stage and output register.
  logic                      s2_v_r;
  rso_pkg::upd_res_t         s2_r, s2_nxt;
  logic                      out_v_r;
  logic signed [31:0]        out_param_r;
  logic [31:0]               out_step_r;
  logic                      out_stop_r, out_improved_r;
  logic [63:0]               norm_r, norm_nxt;
  logic                      stop_nxt;

  // Handshake chain.
  logic out_free, s2_go, s2_free, s1_go, in_xfer;

  assign out_free = !out_v_r || out_ready;
  assign s2_go    = s2_v_r && out_free;
  assign s2_free  = !s2_v_r || out_free;
  assign s1_go    = s1_v_r && s2_free;
  assign in_ready = !s1_v_r || s2_free;
  assign in_xfer  = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_init_r <= rso_pkg::STEP_INIT_RST;
      step_min_r  <= rso_pkg::STEP_MIN_RST;
      step_max_r  <= rso_pkg::STEP_MAX_RST;
      shrink_r    <= rso_pkg::SHRINK_RST;
      grow_r      <= rso_pkg::GROW_RST;
      stop_thr_r  <= rso_pkg::STOP_THR_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (rso_pkg::cfg_reg_t'(cfg_index))
        rso_pkg::CFG_STEP_INIT: step_init_r <= cfg_data[31:0];
        rso_pkg::CFG_STEP_MIN:  step_min_r  <= cfg_data[31:0];
        rso_pkg::CFG_STEP_MAX:  step_max_r  <= cfg_data[31:0];
        rso_pkg::CFG_SHRINK:    shrink_r    <= cfg_data[12:0];
        rso_pkg::CFG_GROW:      grow_r      <= cfg_data[15:0];
        rso_pkg::CFG_STOP_THR:  stop_thr_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Update stage: operand selection with bypass.
  // ---------------------------------------------------------------------
  logic                in_range;
  logic [ADDR_W-1:0]   s1_addr;
  rso_pkg::slot_word_t cur;
  logic signed [31:0]  best_cur;

  assign in_range = (32'(s1_idx_r) < 32'(SLOTS));
  assign s1_addr  = ADDR_W'(s1_idx_r);

  always_comb begin
    if (fwd_a_hit_r) begin
      cur = fwd_a_r;
    end else if (init_r[s1_addr]) begin
      cur = slot_rd_r;
    end else begin
      cur.sign  = rso_pkg::SIGN_ZERO;
      cur.step  = rso_pkg::STEP_INIT_RST;
      cur.param = '0;
    end
    best_cur = fwd_b_hit_r ? fwd_b_r : best_rd_r;
  end

  // Gradient arithmetic.
  logic signed [31:0] grad;
  rso_pkg::sign_t     gsign, eff_sign;
  logic               agree, flip;
  logic [15:0]        factor;
  logic [47:0]        prod;
  logic [31:0]        scaled, new_step;
  logic signed [33:0] np_wide;
  logic signed [31:0] new_param;
  logic [30:0]        mag;
  logic [61:0]        sq;

  always_comb begin
    // Negated gradient; the most negative input saturates.
    grad = (s1_val_r == rso_pkg::PARAM_MIN) ? rso_pkg::PARAM_MAX : -s1_val_r;
    if (grad == '0) begin
      gsign = rso_pkg::SIGN_ZERO;
    end else if (grad[31]) begin
      gsign = rso_pkg::SIGN_NEG;
    end else begin
      gsign = rso_pkg::SIGN_POS;
    end
    agree = (gsign != rso_pkg::SIGN_ZERO) && (cur.sign == gsign);
    flip  = (gsign != rso_pkg::SIGN_ZERO) && (cur.sign != rso_pkg::SIGN_ZERO)
            && (cur.sign != gsign);
    factor = agree ? grow_r : {3'b000, shrink_r};
    prod   = {16'b0, cur.step} * {32'b0, factor};
    scaled = (|prod[47:44]) ? 32'hFFFF_FFFF : prod[43:12];
    if (agree) begin
      new_step = (scaled > step_max_r) ? step_max_r : scaled;
    end else if (flip) begin
      new_step = (scaled < step_min_r) ? step_min_r : scaled;
    end else begin
      new_step = cur.step;
    end
    eff_sign = flip ? rso_pkg::SIGN_ZERO : gsign;
    case (eff_sign)
      rso_pkg::SIGN_POS: np_wide = 34'(cur.param) - $signed({2'b00, new_step});
      rso_pkg::SIGN_NEG: np_wide = 34'(cur.param) + $signed({2'b00, new_step});
      default:           np_wide = 34'(cur.param);
    endcase
    if (np_wide > 34'(rso_pkg::PARAM_MAX)) begin
      new_param = rso_pkg::PARAM_MAX;
    end else if (np_wide < 34'(rso_pkg::PARAM_MIN)) begin
      new_param = rso_pkg::PARAM_MIN;
    end else begin
      new_param = np_wide[31:0];
    end
    // A flipped element contributes nothing to the norm.
    if (flip) begin
      mag = '0;
    end else if (grad[31]) begin
      mag = s1_val_r[30:0];
    end else begin
      mag = grad[30:0];
    end
    sq = {31'b0, mag} * {31'b0, mag};
  end

  // Memory writes and results of the update stage.
  logic                wa_en, wb_en;
  rso_pkg::slot_word_t wa_data;
  logic signed [31:0]  wb_data;
  logic                improve;

  assign improve = !best_valid_r || (s1_val_r > best_score_r);

  always_comb begin
    wa_en   = 1'b0;
    wb_en   = 1'b0;
    wa_data = cur;
    wb_data = s1_val_r;
    snap_nxt = snap_r;
    s2_nxt.param     = '0;
    s2_nxt.step      = '0;
    s2_nxt.improved  = 1'b0;
    s2_nxt.round_end = 1'b0;
    s2_nxt.grad_sq   = '0;
    case (s1_op_r)
      rso_pkg::OP_LOAD: begin
        if (in_range) begin
          wa_en         = 1'b1;
          wb_en         = 1'b1;
          wa_data.sign  = rso_pkg::SIGN_ZERO;
          wa_data.step  = step_init_r;
          wa_data.param = s1_val_r;
          snap_nxt[s1_addr] = 1'b0;
          s2_nxt.param  = s1_val_r;
          s2_nxt.step   = step_init_r;
        end
      end
      rso_pkg::OP_GRAD: begin
        s2_nxt.round_end = s1_last_r;
        if (in_range) begin
          wa_en         = 1'b1;
          wa_data.sign  = eff_sign;
          wa_data.step  = new_step;
          wa_data.param = new_param;
          // Save the snapshot value before the slot moves away from it.
          wb_en   = snap_r[s1_addr];
          wb_data = cur.param;
          snap_nxt[s1_addr] = 1'b0;
          s2_nxt.param   = new_param;
          s2_nxt.step    = new_step;
          s2_nxt.grad_sq = {2'b00, sq};
        end
      end
      rso_pkg::OP_LIKE: begin
        if (improve) begin
          snap_nxt        = '1;
          s2_nxt.improved = 1'b1;
        end
      end
      rso_pkg::OP_READ: begin
        if (in_range) begin
          s2_nxt.param = snap_r[s1_addr] ? cur.param : best_cur;
          s2_nxt.step  = cur.step;
        end
      end
      default: ;
    endcase
    wa_en = wa_en && s1_go;
    wb_en = wb_en && s1_go;
  end

  // Memories: registered read at input transfer, write from the update stage.
  always_ff @(posedge clk) begin
    if (wa_en) begin
      slot_mem[s1_addr] <= wa_data;
    end
    if (wb_en) begin
      best_mem[s1_addr] <= wb_data;
    end
    if (in_xfer) begin
      slot_rd_r   <= slot_mem[ADDR_W'(in_index)];
      best_rd_r   <= best_mem[ADDR_W'(in_index)];
      fwd_a_r     <= wa_data;
      fwd_b_r     <= wb_data;
      fwd_a_hit_r <= wa_en && (s1_idx_r == in_index);
      fwd_b_hit_r <= wb_en && (s1_idx_r == in_index);
      s1_op_r     <= rso_pkg::op_t'(in_operation);
      s1_idx_r    <= in_index;
      s1_val_r    <= in_value;
      s1_last_r   <= in_last;
    end
    if (s1_go) begin
      s2_r <= s2_nxt;
    end
  end

  // Slot flags and best score.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r       <= '0;
      snap_r       <= '1;
      best_score_r <= '0;
      best_valid_r <= 1'b0;
    end else if (s1_go) begin
      snap_r <= snap_nxt;
      if (wa_en) begin
        init_r[s1_addr] <= 1'b1;
      end
      if (s1_op_r == rso_pkg::OP_LOAD) begin
        best_valid_r <= 1'b0;
      end else if (s1_op_r == rso_pkg::OP_LIKE && improve) begin
        best_score_r <= s1_val_r;
        best_valid_r <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Norm and output stage.
  // ---------------------------------------------------------------------
  logic [64:0] norm_sum;

  always_comb begin
    norm_sum = {1'b0, norm_r} + {1'b0, s2_r.grad_sq};
    norm_nxt = norm_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : norm_sum[63:0];
    stop_nxt = s2_r.round_end && (norm_nxt < stop_thr_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      norm_r  <= '0;
    end else begin
      if (in_ready) begin
        s1_v_r <= in_valid;
      end
      if (s2_free) begin
        s2_v_r <= s1_v_r;
      end
      if (out_free) begin
        out_v_r <= s2_v_r;
      end
      if (s2_go) begin
        norm_r <= s2_r.round_end ? '0 : norm_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go) begin
      out_param_r    <= s2_r.param;
      out_step_r     <= s2_r.step;
      out_stop_r     <= stop_nxt;
      out_improved_r <= s2_r.improved;
    end
  end

  assign out_valid       = out_v_r;
  assign out_param_value = out_param_r;
  assign out_step_size   = out_step_r;
  assign out_stop        = out_stop_r;
  assign out_improved    = out_improved_r;

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  `RSO_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid)
  `RSO_ASSERT(a_stall_holds_s1, !in_ready |-> s1_v_r)
  `RSO_ASSERT(a_bypass_needs_write, (in_xfer && !s1_go) |=> (!fwd_a_hit_r && !fwd_b_hit_r))
  `RSO_ASSERT(a_improve_snaps_all, (s1_go && s1_op_r == rso_pkg::OP_LIKE && improve) |=> (snap_r == '1))
  `RSO_ASSERT(a_round_clears_norm, (s2_go && s2_r.round_end) |=> (norm_r == '0))

endmodule
